// File: src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // byte classes made by the front
    localparam logic [2:0] CL_OTHER   = 3'd0;
    localparam logic [2:0] CL_HEX     = 3'd1;
    localparam logic [2:0] CL_CR      = 3'd2;
    localparam logic [2:0] CL_LF      = 3'd3;
    localparam logic [2:0] CL_RESTART = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic [7:0] data;
    } t_item;

endpackage

`default_nettype wire

// File: src/hcbd_if.sv
// ----------------------------------------------------------------------------
// hcbd_if
// Valid/ready channels for body bytes in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [1:0]  status;
    logic [31:0] total_bytes;

    modport source (output valid, output payload_byte, output payload_valid,
                    output status, output total_bytes, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input status, input total_bytes, output ready);
endinterface

`default_nettype wire

// File: src/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts input beats and classifies each byte for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_front (
    hcbd_in_if.sink         i_in,
    output logic            o_push_valid,
    output hcbd_pkg::t_item o_push_item,
    input  logic            i_push_ready
);

    logic       is_num;
    logic       is_upper;
    logic       is_lower;
    logic [7:0] b;

    assign b        = i_in.in_byte;
    assign is_num   = (b >= 8'h30) && (b <= 8'h39);
    assign is_upper = (b >= 8'h41) && (b <= 8'h46);
    assign is_lower = (b >= 8'h61) && (b <= 8'h66);

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_item.data  = b;
        // letters a-f / A-F carry their value in the low nibble plus nine
        o_push_item.digit = is_num ? b[3:0] : b[3:0] + 4'd9;
        if (i_in.action) begin
            o_push_item.cls = hcbd_pkg::CL_RESTART;
        end else if (b == hcbd_pkg::CHAR_CR) begin
            o_push_item.cls = hcbd_pkg::CL_CR;
        end else if (b == hcbd_pkg::CHAR_LF) begin
            o_push_item.cls = hcbd_pkg::CL_LF;
        end else if (is_num || is_upper || is_lower) begin
            o_push_item.cls = hcbd_pkg::CL_HEX;
        end else begin
            o_push_item.cls = hcbd_pkg::CL_OTHER;
        end
    end

endmodule

`default_nettype wire

// File: src/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  hcbd_pkg::t_item i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output hcbd_pkg::t_item o_pop_item,
    input  logic            i_pop_ready
);

    localparam int DEPTH = hcbd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hcbd_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine, size check and registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_back #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            i_pop_valid,
    input  hcbd_pkg::t_item i_pop_item,
    output logic            o_pop_ready,
    hcbd_out_if.source      o_out
);

    localparam int CW = COUNT_WIDTH;
    localparam int SW = ((CW > 32) ? CW : 32) + 1;

    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_SIZE_CR = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_SKIP1   = 3'd3;
    localparam logic [2:0] PH_SKIP2   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_BIG     = 3'd6;

    logic [31:0]   r_max;
    logic [2:0]    r_phase, n_phase;
    logic [CW-1:0] r_chunk_left, n_chunk_left;
    logic [CW-1:0] r_body_total, n_body_total;
    logic          r_out_valid;
    logic [7:0]    r_payload_byte, n_payload_byte;
    logic          r_payload_valid, n_payload_valid;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_total_bytes;

    logic          take;
    logic          restart;
    logic [CW-1:0] digit_acc;
    logic [SW-1:0] need;
    logic          too_big;
    logic [2:0]    eol_phase;
    logic [SW-1:0] total_ext;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign take        = i_pop_valid && o_pop_ready;
    assign restart     = (i_pop_item.cls == hcbd_pkg::CL_RESTART);

    // hex accumulator saturates once a shift would lose bits
    assign digit_acc = (|r_chunk_left[CW-1 -: 4]) ? '1
                     : {r_chunk_left[CW-5:0], i_pop_item.digit};

    // new chunk fits when total plus size stays within the maximum
    assign need      = SW'(r_chunk_left) + SW'(r_body_total);
    assign too_big   = need > SW'(r_max);
    assign eol_phase = too_big ? PH_BIG : (r_chunk_left == '0) ? PH_DONE : PH_DATA;

    always_comb begin
        n_phase         = r_phase;
        n_chunk_left    = r_chunk_left;
        n_body_total    = r_body_total;
        n_payload_byte  = '0;
        n_payload_valid = 1'b0;
        if (restart) begin
            n_phase      = PH_SIZE;
            n_chunk_left = '0;
            n_body_total = '0;
        end else begin
            unique case (r_phase) inside
                PH_SIZE: begin
                    if (i_pop_item.cls == hcbd_pkg::CL_CR) begin
                        n_phase = PH_SIZE_CR;
                    end else if (i_pop_item.cls == hcbd_pkg::CL_HEX) begin
                        n_chunk_left = digit_acc;
                    end
                end
                PH_SIZE_CR: begin
                    if (i_pop_item.cls == hcbd_pkg::CL_LF) begin
                        n_phase = eol_phase;
                    end else if (i_pop_item.cls != hcbd_pkg::CL_CR) begin
                        n_phase = PH_SIZE;
                        if (i_pop_item.cls == hcbd_pkg::CL_HEX) begin
                            n_chunk_left = digit_acc;
                        end
                    end
                end
                PH_DATA: begin
                    n_payload_byte  = i_pop_item.data;
                    n_payload_valid = 1'b1;
                    if (r_chunk_left != '0) begin
                        n_chunk_left = r_chunk_left - 1'b1;
                    end
                    if (r_body_total != '1) begin
                        n_body_total = r_body_total + 1'b1;
                    end
                    if (n_chunk_left == '0) begin
                        n_phase = PH_SKIP1;
                    end
                end
                PH_SKIP1: begin
                    n_phase = PH_SKIP2;
                end
                PH_SKIP2: begin
                    n_phase      = PH_SIZE;
                    n_chunk_left = '0;
                end
                PH_DONE, PH_BIG: begin
                end
                default: begin
                    n_phase = PH_SIZE;
                end
            endcase
        end
        if (n_phase == PH_DONE) begin
            n_status = hcbd_pkg::ST_DONE;
        end else if (n_phase == PH_BIG) begin
            n_status = hcbd_pkg::ST_BIG;
        end else begin
            n_status = hcbd_pkg::ST_BUSY;
        end
    end

    assign total_ext = SW'(n_body_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= hcbd_pkg::MAX_BODY_RESET;
            r_phase      <= PH_SIZE;
            r_chunk_left <= '0;
            r_body_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (take) begin
                r_phase      <= n_phase;
                r_chunk_left <= n_chunk_left;
                r_body_total <= n_body_total;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_payload_byte  <= n_payload_byte;
            r_payload_valid <= n_payload_valid;
            r_status        <= n_status;
            r_total_bytes   <= total_ext[31:0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_payload_byte;
    assign o_out.payload_valid = r_payload_valid;
    assign o_out.status        = r_status;
    assign o_out.total_bytes   = r_total_bytes;

    a_take_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("taken byte produced no result beat");

    a_payload_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_payload_valid) |-> (r_status == hcbd_pkg::ST_BUSY))
        else $error("payload beat with final status");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(take && restart) |=> (r_body_total >= $past(r_body_total)))
        else $error("body total went down without restart");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_DONE || r_phase == PH_BIG) && !(take && restart))
        |=> (r_phase == $past(r_phase)))
        else $error("final phase left without restart");

endmodule

`default_nettype wire

// File: src/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Chunked transfer body decoder: one body byte in, one result beat out.
// ----------------------------------------------------------------------------
//  port     dir   handshake      payload
//  i_in     in    valid/ready    action, in_byte
//  o_out    out   valid/ready    payload_byte, payload_valid, status, total_bytes
//  i_cfg    in    i_cfg_we       i_cfg_wdata (max_body_bytes)
//
//  one beat in and one beat out per cycle when both sides keep moving
//  each byte is classified into the queue, then the state machine writes
//  the result register
//  a two-entry queue parts front and back; a stalled output fills it and
//  then drops i_in.ready
//  i_rst_n is synchronous; reset sets max_body_bytes to 1048576
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_top #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);

    logic            push_valid;
    logic            push_ready;
    hcbd_pkg::t_item push_item;
    logic            pop_valid;
    logic            pop_ready;
    hcbd_pkg::t_item pop_item;

    hcbd_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    hcbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    hcbd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked body decoder. A queue of body beats
// (chunked bodies with random content, some malformed, plus raw noise) feeds a
// valid/ready driver. A scoreboard decodes every accepted beat on its own and
// checks each output beat field by field. The size limit is rewritten between
// phases while the decoder is idle, and both sides idle at random but in the last phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COUNT_W     = hcbd_pkg::COUNT_WIDTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_SIZE, PH_SIZE_CR, PH_DATA, PH_SKIP1, PH_SKIP2, PH_DONE, PH_BIG
    } t_dec_phase;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } t_body_beat;

    typedef struct packed {
        logic [7:0]  pbyte;
        logic        pvalid;
        logic [1:0]  status;
        logic [31:0] total;
    } t_dec_result;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    hcbd_in_if  in_if ();
    hcbd_out_if out_if ();

    http_chunked_body_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // scoreboard copy of the decoder
    t_dec_phase         dec_phase;
    logic [COUNT_W-1:0] chunk_left;
    logic [COUNT_W-1:0] body_total;
    logic [31:0]        max_body;

    t_body_beat  byte_feed[$];
    t_dec_result expected_results[$];
    t_body_beat  next_beat;

    int  beats_queued = 0;
    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  send_gap     = 0;
    int  hold_left    = 0;
    int  holds_asked  = 0;
    int  holds_served = 0;
    bit  calm         = 0;
    bit  in_taken     = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    // saturating shift-in of one hex digit
    function automatic logic [COUNT_W-1:0] shift_digit(input logic [COUNT_W-1:0] acc,
                                                       input int d);
        if (acc > ({COUNT_W{1'b1}} >> 4)) return {COUNT_W{1'b1}};
        return (acc << 4) | COUNT_W'(d);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return "0" + {4'h0, n};
        if (upper) return "A" + {4'h0, n - 4'd10};
        return "a" + {4'h0, n - 4'd10};
    endfunction

    task automatic decode_beat(input logic act, input logic [7:0] b);
        t_dec_result r;
        int d;
        r = '0;
        if (act == ACT_RESTART) begin
            dec_phase  = PH_SIZE;
            chunk_left = '0;
            body_total = '0;
        end else begin
            case (dec_phase) inside
                PH_SIZE: begin
                    if (b == hcbd_pkg::CHAR_CR) begin
                        dec_phase = PH_SIZE_CR;
                    end else begin
                        d = hex_val(b);
                        if (d >= 0) chunk_left = shift_digit(chunk_left, d);
                    end
                end
                PH_SIZE_CR: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        // too-large wins over the zero-size check
                        if (body_total > COUNT_W'(max_body))
                            dec_phase = PH_BIG;
                        else if (chunk_left > COUNT_W'(max_body) - body_total)
                            dec_phase = PH_BIG;
                        else if (chunk_left == '0)
                            dec_phase = PH_DONE;
                        else
                            dec_phase = PH_DATA;
                    end else if (b != hcbd_pkg::CHAR_CR) begin
                        d = hex_val(b);
                        if (d >= 0) chunk_left = shift_digit(chunk_left, d);
                        dec_phase = PH_SIZE;
                    end
                end
                PH_DATA: begin
                    r.pbyte  = b;
                    r.pvalid = 1'b1;
                    if (chunk_left != '0) chunk_left = chunk_left - 1'b1;
                    if (body_total != {COUNT_W{1'b1}}) body_total = body_total + 1'b1;
                    if (chunk_left == '0) dec_phase = PH_SKIP1;
                end
                PH_SKIP1: dec_phase = PH_SKIP2;
                PH_SKIP2: begin
                    dec_phase  = PH_SIZE;
                    chunk_left = '0;
                end
                PH_DONE, PH_BIG: ;
                default: dec_phase = PH_SIZE;
            endcase
        end
        if (dec_phase == PH_DONE)     r.status = hcbd_pkg::ST_DONE;
        else if (dec_phase == PH_BIG) r.status = hcbd_pkg::ST_BIG;
        else                          r.status = hcbd_pkg::ST_BUSY;
        r.total = body_total[31:0];
        expected_results.push_back(r);
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic push_beat(input logic act, input logic [7:0] data);
        t_body_beat bb;
        bb.act  = act;
        bb.data = data;
        byte_feed.push_back(bb);
        beats_queued++;
    endtask

    task automatic push_noise(input int n);
        repeat (n)
            push_beat(($urandom_range(0, 9) == 0) ? ACT_RESTART : ACT_BYTE,
                      8'($urandom_range(0, 255)));
    endtask

    task automatic push_size_line(input logic [31:0] s);
        int ndig;
        int i;
        ndig = 1;
        while (ndig < 8 && (s >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_beat(ACT_BYTE, "0");
        for (i = ndig - 1; i >= 0; i--)
            push_beat(ACT_BYTE, hex_char(4'(s >> (4 * i)), 1'($urandom_range(0, 1))));
        // chunk extension made only of non-hex bytes, sometimes with a lone CR
        if ($urandom_range(0, 4) == 0) begin
            push_beat(ACT_BYTE, ";");
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 5))
                    0: push_beat(ACT_BYTE, "=");
                    1: push_beat(ACT_BYTE, "x");
                    2: push_beat(ACT_BYTE, "z");
                    3: push_beat(ACT_BYTE, " ");
                    4: begin
                        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
                        push_beat(ACT_BYTE, "q");
                    end
                    default: push_beat(ACT_BYTE, "_");
                endcase
            end
        end
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
    endtask

    task automatic push_body();
        int nchunks;
        int unsigned s;
        push_beat(ACT_RESTART, 8'($urandom_range(0, 255)));
        nchunks = $urandom_range(0, 3);
        repeat (nchunks) begin
            // oversized chunk only where it is sure to be refused
            if (max_body < 32'h10000 && $urandom_range(0, 7) == 0) begin
                push_size_line($urandom() | 32'h10000);
                push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
                return;
            end
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            push_size_line(s);
            repeat (s) push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
                push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
                push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
                push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            push_size_line(0);
            if ($urandom_range(0, 1)) push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_mix(input int n);
        int stop_at;
        stop_at = beats_queued + n;
        while (beats_queued < stop_at) begin
            if ($urandom_range(0, 3) != 0) push_body();
            else push_noise($urandom_range(1, 8));
        end
    endtask

    task automatic wait_idle();
        while (byte_feed.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_max(input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        max_body   = v;
    endtask

    initial begin
        int unsigned s;
        int i;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_if.valid    = 1'b0;
        in_if.action   = ACT_BYTE;
        in_if.in_byte  = '0;
        out_if.ready   = 1'b0;
        dec_phase      = PH_SIZE;
        chunk_left     = '0;
        body_total     = '0;
        max_body       = hcbd_pkg::MAX_BODY_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // junk and a lone CR in the size line, extreme data, unchecked trailer,
        // CR CR LF ending the last-chunk line
        push_beat(ACT_RESTART, 8'hFF);
        push_beat(ACT_BYTE, "g");
        push_beat(ACT_BYTE, "2");
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, "Z");
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
        push_beat(ACT_BYTE, 8'h00);
        push_beat(ACT_BYTE, 8'hFF);
        push_beat(ACT_BYTE, "x");
        push_beat(ACT_BYTE, "y");
        push_beat(ACT_BYTE, "0");
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
        // saturating size in mixed case, refused, then ignored
        push_beat(ACT_RESTART, 8'h00);
        for (i = 0; i < 9; i++) push_beat(ACT_BYTE, (i % 2) ? "f" : "F");
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
        push_beat(ACT_BYTE, 8'h5A);
        wait_idle();

        write_max(32'hFFFF_FFFF);
        run_mix(110);
        holds_asked++;
        wait_idle();

        // limit dropped below the running total, then a last-chunk line
        s = $urandom_range(6, 10);
        push_beat(ACT_RESTART, 8'($urandom_range(0, 255)));
        push_size_line(s);
        repeat (s) push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_CR);
        push_beat(ACT_BYTE, hcbd_pkg::CHAR_LF);
        wait_idle();
        write_max($urandom_range(0, s - 1));
        push_size_line(0);
        push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        wait_idle();

        write_max(32'h0);
        run_mix(60);
        wait_idle();

        write_max($urandom_range(16, 64));
        run_mix(110);
        wait_idle();

        write_max(hcbd_pkg::MAX_BODY_RESET);
        calm = 1'b1;
        run_mix(140);
        wait_idle();
        repeat (8) @(negedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------ driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_if.valid && !in_taken) begin
            // beat still waiting for ready
        end else if (send_gap != 0) begin
            send_gap    <= send_gap - 1;
            in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap    <= $urandom_range(0, 8);
            in_if.valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
            next_beat      = byte_feed.pop_front();
            in_if.valid   <= 1'b1;
            in_if.action  <= next_beat.act;
            in_if.in_byte <= next_beat.data;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // output side ready, with one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left    <= $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ----------------------------------------------------------------- monitor
    always @(posedge clk) begin
        t_dec_result exp_r;
        if (!rst_n) begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    err_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_if.payload_byte !== exp_r.pbyte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               exp_r.pbyte, out_if.payload_byte);
                        err_count++;
                    end
                    if (out_if.payload_valid !== exp_r.pvalid) begin
                        $error("payload_valid: expected %0b, got %0b",
                               exp_r.pvalid, out_if.payload_valid);
                        err_count++;
                    end
                    if (out_if.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
                        err_count++;
                    end
                    if (out_if.total_bytes !== exp_r.total) begin
                        $error("total_bytes: expected %0d, got %0d",
                               exp_r.total, out_if.total_bytes);
                        err_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) decode_beat(in_if.action, in_if.in_byte);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
